@@ src/rmsp_pkg.sv @@
`timescale 1ns / 1ps
package rmsp_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EPSILON = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOMENTUM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTERED = 3'd4;

   typedef struct packed {
      logic [30:0] step_size;
      logic [30:0] epsilon;
      logic [16:0] decay;
      logic [16:0] momentum;
      logic        centered;
   } rmsp_cfg_type;

   typedef struct packed {
      logic signed [31:0] param;
      logic signed [31:0] grad;
      logic signed [31:0] moment;
      logic [30:0]        sq_avg;
      logic signed [31:0] mean_grad;
      logic [31:0]        root_arg;
      logic               clamped;
   } rmsp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rmsp_queue_status_type;

   function automatic logic signed [63:0] sat_q(input logic signed [63:0] x, input int bits);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (x > hi) begin
         return hi;
      end else if (x < lo) begin
         return lo;
      end
      return x;
   endfunction

endpackage

@@ src/rmsprop_param_update_core.sv @@
`timescale 1ns / 1ps
// RMSProp update with momentum and optional centered mode, signed Q fixed point.
// Takes one element per clock cycle while busy is low and returns exactly one result
// per element. RB = (33 + FRAC_BITS) / 2 is the number of one-bit root stages and
// QB = min(max(DATA_WIDTH, 16), 32) - 1 is the number of one-bit quotient stages.
// The result is shown for exactly one cycle with rsp_strobe and cannot be held off.
// Write the csr_ registers only while no element is in flight.
module rmsprop_param_update_core #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [31:0]                    req_param_value,
   input  logic [30:0]                           req_sq_avg_value,
   input  logic signed [31:0]                    req_gradient,
   input  logic signed [31:0]                    req_moment_value,
   input  logic signed [31:0]                    req_mean_grad_value,
   output logic                                  rsp_strobe,
   output logic signed [31:0]                    rsp_param_new,
   output logic signed [31:0]                    rsp_moment_new,
   output logic [30:0]                           rsp_sq_avg_new,
   output logic signed [31:0]                    rsp_mean_grad_new,
   output logic                                  rsp_root_clamped,
   input  logic                                  csr_write_enable,
   input  logic [rmsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rmsp_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   rmsp_pkg::rmsp_cfg_type cfg_ff, cfg_in;
   rmsp_pkg::rmsp_item_type front_item, head_item;
   rmsp_pkg::rmsp_queue_status_type qstat;
   logic front_valid;
   logic accept;
   logic pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rmsp_pkg::CSR_STEP_SIZE: cfg_in.step_size = csr_write_data;
            rmsp_pkg::CSR_EPSILON: cfg_in.epsilon = csr_write_data;
            rmsp_pkg::CSR_DECAY: cfg_in.decay = csr_write_data[16:0];
            rmsp_pkg::CSR_MOMENTUM: cfg_in.momentum = csr_write_data[16:0];
            rmsp_pkg::CSR_CENTERED: cfg_in.centered = csr_write_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size <= 31'd66;
         cfg_ff.epsilon <= 31'd1;
         cfg_ff.decay <= 17'd62259;
         cfg_ff.momentum <= 17'd0;
         cfg_ff.centered <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy = qstat.full;
   assign accept = start && !busy;
   assign pop = !qstat.empty;

   rmsp_front #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .in_valid(accept),
      .in_param(req_param_value),
      .in_sq_avg(req_sq_avg_value),
      .in_grad(req_gradient),
      .in_moment(req_moment_value),
      .in_mean_grad(req_mean_grad_value),
      .out_valid(front_valid),
      .out_item(front_item)
   );

   rmsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(front_valid),
      .push_item(front_item),
      .pop(pop),
      .head_item(head_item),
      .status(qstat)
   );

   rmsp_back #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .in_valid(pop),
      .in_item(head_item),
      .out_valid(rsp_strobe),
      .out_param(rsp_param_new),
      .out_moment(rsp_moment_new),
      .out_sq_avg(rsp_sq_avg_new),
      .out_mean_grad(rsp_mean_grad_new),
      .out_clamped(rsp_root_clamped)
   );

   a_queue_no_drop: assert property (@(posedge clock) disable iff (reset)
      !(front_valid && qstat.full))
      else $error("transfer into full queue");

   a_no_strobe_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   a_pop_when_filled: assert property (@(posedge clock) disable iff (reset)
      $past(front_valid) && !$past(reset) |-> !qstat.empty)
      else $error("queue lost a transfer");

endmodule

@@ src/rmsp_front.sv @@
`timescale 1ns / 1ps
module rmsp_front #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rmsp_pkg::rmsp_cfg_type cfg,
   input  logic                  in_valid,
   input  logic signed [31:0]    in_param,
   input  logic [30:0]           in_sq_avg,
   input  logic signed [31:0]    in_grad,
   input  logic signed [31:0]    in_moment,
   input  logic signed [31:0]    in_mean_grad,
   output logic                  out_valid,
   output rmsp_pkg::rmsp_item_type out_item
);

   localparam int SAT_BITS = (DATA_WIDTH < 16) ? 16 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
   localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

   logic [31:0] rho;
   logic [31:0] omr;

   logic [5:0] valid_ff;
   logic [5:0] valid_in;

   logic signed [31:0] p0_ff, g0_ff, mom0_ff, mg0_ff;
   logic [30:0]        ms0_ff;

   logic signed [31:0] p1_ff, g1_ff, mom1_ff, mg1_ff;
   logic signed [63:0] gg_ff, rms_ff, omrg_ff, rmg_ff;
   logic signed [63:0] gg_in, rms_in, omrg_in, rmg_in;

   logic signed [31:0] p2_ff, g2x_ff, mom2_ff, g2_ff, mgn2_ff;
   logic [31:0]        ams2_ff;
   logic signed [31:0] g2_in, mgn2_in;
   logic signed [63:0] mg_sum;

   logic signed [31:0] p3_ff, g3_ff, mom3_ff, mgn3_ff;
   logic [31:0]        ams3_ff;
   logic signed [63:0] b3_ff, sq3_ff, b3_in, sq3_in;

   logic signed [31:0] p4_ff, g4_ff, mom4_ff, mgn4_ff, sq4_ff;
   logic [30:0]        ms4_ff;
   logic signed [63:0] ms_sum;
   logic [30:0]        ms4_in;
   logic signed [31:0] sq4_in;

   rmsp_pkg::rmsp_item_type item_ff, item_in;
   logic signed [33:0] arg;

   always_comb begin
      rho = ({15'd0, cfg.decay} > ONE_Q) ? ONE_Q : {15'd0, cfg.decay};
      omr = ONE_Q - rho;
   end

   assign valid_in = {valid_ff[4:0], in_valid};

   assign gg_in = g0_ff * g0_ff;
   assign rms_in = $signed({1'b0, rho}) * $signed({2'b00, ms0_ff});
   assign omrg_in = $signed({1'b0, omr}) * g0_ff;
   assign rmg_in = $signed({1'b0, rho}) * mg0_ff;

   always_comb begin
      g2_in = 32'(rmsp_pkg::sat_q(gg_ff >>> FRAC_BITS, SAT_BITS));
      mg_sum = rmsp_pkg::sat_q((rmg_ff >>> FRAC_BITS) + (omrg_ff >>> FRAC_BITS), SAT_BITS);
      mgn2_in = cfg.centered ? 32'(mg_sum) : mg1_ff;
   end

   assign b3_in = $signed({1'b0, omr}) * g2_ff;
   assign sq3_in = mgn2_ff * mgn2_ff;

   always_comb begin
      ms_sum = rmsp_pkg::sat_q($signed({32'd0, ams3_ff}) + (b3_ff >>> FRAC_BITS), SAT_BITS);
      ms4_in = (ms_sum < 0) ? 31'd0 : ms_sum[30:0];
      sq4_in = 32'(rmsp_pkg::sat_q(sq3_ff >>> FRAC_BITS, SAT_BITS));
   end

   always_comb begin
      arg = $signed({3'b000, ms4_ff}) + $signed({3'b000, cfg.epsilon});
      if (cfg.centered) begin
         arg = arg - $signed({{2{sq4_ff[31]}}, sq4_ff});
      end
      item_in.param = p4_ff;
      item_in.grad = g4_ff;
      item_in.moment = mom4_ff;
      item_in.sq_avg = ms4_ff;
      item_in.mean_grad = mgn4_ff;
      if (arg[33] || arg == 34'sd0) begin
         item_in.root_arg = 32'd1;
         item_in.clamped = 1'b1;
      end else begin
         item_in.root_arg = arg[31:0];
         item_in.clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff <= in_param;
      ms0_ff <= in_sq_avg;
      g0_ff <= in_grad;
      mom0_ff <= in_moment;
      mg0_ff <= in_mean_grad;

      p1_ff <= p0_ff;
      g1_ff <= g0_ff;
      mom1_ff <= mom0_ff;
      mg1_ff <= mg0_ff;
      gg_ff <= gg_in;
      rms_ff <= rms_in;
      omrg_ff <= omrg_in;
      rmg_ff <= rmg_in;

      p2_ff <= p1_ff;
      g2x_ff <= g1_ff;
      mom2_ff <= mom1_ff;
      g2_ff <= g2_in;
      mgn2_ff <= mgn2_in;
      ams2_ff <= 32'(rms_ff >>> FRAC_BITS);

      p3_ff <= p2_ff;
      g3_ff <= g2x_ff;
      mom3_ff <= mom2_ff;
      mgn3_ff <= mgn2_ff;
      ams3_ff <= ams2_ff;
      b3_ff <= b3_in;
      sq3_ff <= sq3_in;

      p4_ff <= p3_ff;
      g4_ff <= g3_ff;
      mom4_ff <= mom3_ff;
      mgn4_ff <= mgn3_ff;
      ms4_ff <= ms4_in;
      sq4_ff <= sq4_in;

      item_ff <= item_in;
   end

   assign out_valid = valid_ff[5];
   assign out_item = item_ff;

endmodule

@@ src/rmsp_queue.sv @@
`timescale 1ns / 1ps
module rmsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  rmsp_pkg::rmsp_item_type       push_item,
   input  logic                          pop,
   output rmsp_pkg::rmsp_item_type       head_item,
   output rmsp_pkg::rmsp_queue_status_type status
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   rmsp_pkg::rmsp_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full = (count_ff == (PTR_W+1)'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = mem_ff[rd_ptr_ff];

endmodule

@@ src/rmsp_back.sv @@
`timescale 1ns / 1ps
module rmsp_back #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rmsp_pkg::rmsp_cfg_type  cfg,
   input  logic                    in_valid,
   input  rmsp_pkg::rmsp_item_type in_item,
   output logic                    out_valid,
   output logic signed [31:0]      out_param,
   output logic signed [31:0]      out_moment,
   output logic [30:0]             out_sq_avg,
   output logic signed [31:0]      out_mean_grad,
   output logic                    out_clamped
);

   localparam int SAT_BITS = (DATA_WIDTH < 16) ? 16 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
   localparam int QB = SAT_BITS - 1;
   localparam int RB = (33 + FRAC_BITS) / 2;
   localparam int RADW = 2 * RB;
   localparam int DW = ((RB + QB) > 63 ? (RB + QB) : 63) + 1;
   localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
   localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_MIN = -SAT_MAX - 64'sd1;

   typedef struct packed {
      logic signed [31:0] param;
      logic signed [31:0] mmq;
      logic               nneg;
      logic [62:0]        nmag;
      logic [30:0]        sq_avg;
      logic signed [31:0] mean_grad;
      logic               clamped;
   } rmsp_carry_type;

   logic [31:0] mu;
   logic        b0_valid_ff;
   rmsp_pkg::rmsp_item_type b0_item_ff;
   logic signed [63:0] nprod_ff, mm_ff, nprod_in, mm_in;

   logic           s_valid [0:RB];
   rmsp_carry_type s_carry [0:RB];
   logic [RADW-1:0] s_rem  [0:RB];
   logic [RB-1:0]   s_root [0:RB];

   logic           ov_valid_ff;
   rmsp_carry_type ov_carry_ff;
   logic [RB-1:0]  ov_root_ff;
   logic           ov_flag_ff;

   logic           d_valid [0:QB];
   rmsp_carry_type d_carry [0:QB];
   logic [DW-1:0]  d_rem   [0:QB];
   logic [QB-1:0]  d_q     [0:QB];
   logic [RB-1:0]  d_root  [0:QB];

   logic               f0_valid_ff, f1_valid_ff, f2_valid_ff;
   rmsp_carry_type     f0_carry_ff, f1_carry_ff;
   logic signed [31:0] quot_ff, quot_in;
   logic signed [31:0] mom_ff, mom_in;
   logic signed [31:0] pnew_ff, pnew_in;
   logic signed [31:0] mom2_ff;
   logic [30:0]        ms2_ff;
   logic signed [31:0] mg2_ff;
   logic               cl2_ff;

   always_comb begin
      mu = ({15'd0, cfg.momentum} > ONE_Q) ? ONE_Q : {15'd0, cfg.momentum};
   end

   assign nprod_in = $signed({1'b0, cfg.step_size}) * in_item.grad;
   assign mm_in = $signed({1'b0, mu}) * in_item.moment;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
      end else begin
         b0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      b0_item_ff <= in_item;
      nprod_ff <= nprod_in;
      mm_ff <= mm_in;
   end

   always_comb begin
      s_valid[0] = b0_valid_ff;
      s_carry[0].param = b0_item_ff.param;
      s_carry[0].mmq = 32'(mm_ff >>> FRAC_BITS);
      s_carry[0].nneg = nprod_ff[63];
      s_carry[0].nmag = nprod_ff[63] ? 63'(-nprod_ff) : nprod_ff[62:0];
      s_carry[0].sq_avg = b0_item_ff.sq_avg;
      s_carry[0].mean_grad = b0_item_ff.mean_grad;
      s_carry[0].clamped = b0_item_ff.clamped;
      s_rem[0] = RADW'(b0_item_ff.root_arg) << FRAC_BITS;
      s_root[0] = '0;
   end

   for (genvar k = 0; k < RB; k++) begin : g_sqrt
      localparam int BIT = RB - 1 - k;
      logic [RADW-1:0] cand;
      logic            take;
      logic            valid_ff;
      rmsp_carry_type  carry_ff;
      logic [RADW-1:0] rem_ff;
      logic [RB-1:0]   root_ff;

      assign cand = (RADW'(s_root[k]) << (BIT + 1)) + (RADW'(1) << (2 * BIT));
      assign take = (s_rem[k] >= cand);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= s_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         carry_ff <= s_carry[k];
         rem_ff <= take ? s_rem[k] - cand : s_rem[k];
         root_ff <= take ? (s_root[k] | (RB'(1) << BIT)) : s_root[k];
      end

      assign s_valid[k+1] = valid_ff;
      assign s_carry[k+1] = carry_ff;
      assign s_rem[k+1] = rem_ff;
      assign s_root[k+1] = root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_valid_ff <= 1'b0;
      end else begin
         ov_valid_ff <= s_valid[RB];
      end
   end

   always_ff @(posedge clock) begin
      ov_carry_ff <= s_carry[RB];
      ov_root_ff <= s_root[RB];
      ov_flag_ff <= (DW'(s_carry[RB].nmag) >= (DW'(s_root[RB]) << QB));
   end

   always_comb begin
      d_valid[0] = ov_valid_ff;
      d_carry[0] = ov_carry_ff;
      d_rem[0] = DW'(ov_carry_ff.nmag);
      d_q[0] = '0;
      d_root[0] = ov_root_ff;
   end

   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int BIT = QB - 1 - j;
      logic [DW-1:0]  sub;
      logic           take;
      logic           valid_ff;
      rmsp_carry_type carry_ff;
      logic [DW-1:0]  rem_ff;
      logic [QB-1:0]  q_ff;
      logic [RB-1:0]  root_ff;

      assign sub = DW'(d_root[j]) << BIT;
      assign take = (d_rem[j] >= sub);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= d_valid[j];
         end
      end

      always_ff @(posedge clock) begin
         carry_ff <= d_carry[j];
         rem_ff <= take ? d_rem[j] - sub : d_rem[j];
         q_ff <= take ? (d_q[j] | (QB'(1) << BIT)) : d_q[j];
         root_ff <= d_root[j];
      end

      assign d_valid[j+1] = valid_ff;
      assign d_carry[j+1] = carry_ff;
      assign d_rem[j+1] = rem_ff;
      assign d_q[j+1] = q_ff;
      assign d_root[j+1] = root_ff;
   end

   logic ovf_pipe [0:QB];
   assign ovf_pipe[0] = ov_flag_ff;
   for (genvar j = 0; j < QB; j++) begin : g_ovf
      logic flag_ff;
      always_ff @(posedge clock) begin
         flag_ff <= ovf_pipe[j];
      end
      assign ovf_pipe[j+1] = flag_ff;
   end

   always_comb begin
      if (ovf_pipe[QB]) begin
         quot_in = d_carry[QB].nneg ? 32'(SAT_MIN) : 32'(SAT_MAX);
      end else if (d_carry[QB].nneg) begin
         quot_in = -$signed(32'(d_q[QB]));
      end else begin
         quot_in = $signed(32'(d_q[QB]));
      end
      mom_in = 32'(rmsp_pkg::sat_q(64'(f0_carry_ff.mmq) + 64'(quot_ff), SAT_BITS));
      pnew_in = 32'(rmsp_pkg::sat_q(64'(f1_carry_ff.param) - 64'(mom_ff), SAT_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f0_valid_ff <= d_valid[QB];
         f1_valid_ff <= f0_valid_ff;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f0_carry_ff <= d_carry[QB];
      quot_ff <= quot_in;
      f1_carry_ff <= f0_carry_ff;
      mom_ff <= mom_in;
      pnew_ff <= pnew_in;
      mom2_ff <= mom_ff;
      ms2_ff <= f1_carry_ff.sq_avg;
      mg2_ff <= f1_carry_ff.mean_grad;
      cl2_ff <= f1_carry_ff.clamped;
   end

   assign out_valid = f2_valid_ff;
   assign out_param = pnew_ff;
   assign out_moment = mom2_ff;
   assign out_sq_avg = ms2_ff;
   assign out_mean_grad = mg2_ff;
   assign out_clamped = cl2_ff;

endmodule

@@ tb/sv/rmsprop_param_update_core_test.sv @@
`timescale 1ns / 1ps
module rmsprop_param_update_core_test;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int LATENCY = 67;

   typedef struct {
      logic signed [31:0] param;
      logic [30:0]        sq_avg;
      logic signed [31:0] grad;
      logic signed [31:0] moment;
      logic signed [31:0] mean_grad;
   } element_type;

   typedef struct {
      logic signed [31:0] param_new;
      logic signed [31:0] moment_new;
      logic [30:0]        sq_avg_new;
      logic signed [31:0] mean_grad_new;
      logic               clamped;
   } update_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [31:0] req_param_value;
   logic [30:0] req_sq_avg_value;
   logic signed [31:0] req_gradient;
   logic signed [31:0] req_moment_value;
   logic signed [31:0] req_mean_grad_value;
   logic rsp_strobe;
   logic signed [31:0] rsp_param_new;
   logic signed [31:0] rsp_moment_new;
   logic [30:0] rsp_sq_avg_new;
   logic signed [31:0] rsp_mean_grad_new;
   logic rsp_root_clamped;
   logic csr_write_enable;
   logic [rmsp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rmsp_pkg::CSR_DATA_W-1:0] csr_write_data;

   logic [30:0] lr_q;
   logic [30:0] eps_q;
   logic [16:0] decay_q;
   logic [16:0] momentum_q;
   logic        centered_q;

   update_type pending_updates[$];
   int mismatches;
   int cycles;
   int idle_pct;

   rmsprop_param_update_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_param_value(req_param_value), .req_sq_avg_value(req_sq_avg_value),
      .req_gradient(req_gradient), .req_moment_value(req_moment_value),
      .req_mean_grad_value(req_mean_grad_value),
      .rsp_strobe(rsp_strobe), .rsp_param_new(rsp_param_new),
      .rsp_moment_new(rsp_moment_new), .rsp_sq_avg_new(rsp_sq_avg_new),
      .rsp_mean_grad_new(rsp_mean_grad_new), .rsp_root_clamped(rsp_root_clamped),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic update_type rms_update(element_type e);
      update_type u;
      longint g, ms, mg, mom, rho, mu, g2, msn, mgn, arg, root, quot, momn;
      g = e.grad;
      ms = e.sq_avg;
      mg = e.mean_grad;
      mom = e.moment;
      rho = (decay_q > 17'd65536) ? 65536 : decay_q;
      mu = (momentum_q > 17'd65536) ? 65536 : momentum_q;
      u.clamped = 1'b0;
      g2 = sat32((g * g) >>> 16);
      msn = sat32(((rho * ms) >>> 16) + (((65536 - rho) * g2) >>> 16));
      if (msn < 0) msn = 0;
      if (centered_q) begin
         mgn = sat32(((rho * mg) >>> 16) + (((65536 - rho) * g) >>> 16));
         arg = msn - sat32((mgn * mgn) >>> 16) + longint'(eps_q);
      end else begin
         mgn = mg;
         arg = msn + longint'(eps_q);
      end
      if (arg <= 0) begin
         arg = 1;
         u.clamped = 1'b1;
      end
      root = longint'(int_sqrt(longint'(arg) << 16));
      if (root < 1) root = 1;
      quot = sat32((longint'(lr_q) * g) / root);
      momn = sat32(((mu * mom) >>> 16) + quot);
      u.param_new = 32'(sat32(longint'(e.param) - momn));
      u.moment_new = 32'(momn);
      u.sq_avg_new = 31'(msn);
      u.mean_grad_new = 32'(mgn);
      return u;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("ERROR %0s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   always @(posedge clock) begin
      update_type u;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("rmsprop_param_update_core_test failed");
         $finish;
      end else if (!reset && rsp_strobe) begin
         if (pending_updates.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            u = pending_updates.pop_front();
            if (rsp_param_new !== u.param_new)
               report_mismatch("param_new", rsp_param_new, u.param_new);
            if (rsp_moment_new !== u.moment_new)
               report_mismatch("moment_new", rsp_moment_new, u.moment_new);
            if (rsp_sq_avg_new !== u.sq_avg_new)
               report_mismatch("sq_avg_new", rsp_sq_avg_new, u.sq_avg_new);
            if (rsp_mean_grad_new !== u.mean_grad_new)
               report_mismatch("mean_grad_new", rsp_mean_grad_new, u.mean_grad_new);
            if (rsp_root_clamped !== u.clamped)
               report_mismatch("root_clamped", rsp_root_clamped, u.clamped);
         end
      end
   end

   task automatic send_element(element_type e);
      int gap;
      start <= 1'b1;
      req_param_value <= e.param;
      req_sq_avg_value <= e.sq_avg;
      req_gradient <= e.grad;
      req_moment_value <= e.moment;
      req_mean_grad_value <= e.mean_grad;
      do @(posedge clock); while (busy);
      pending_updates.push_back(rms_update(e));
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [rmsp_pkg::CSR_INDEX_W-1:0] idx, logic [30:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         rmsp_pkg::CSR_STEP_SIZE: lr_q = data;
         rmsp_pkg::CSR_EPSILON: eps_q = data;
         rmsp_pkg::CSR_DECAY: decay_q = data[16:0];
         rmsp_pkg::CSR_MOMENTUM: momentum_q = data[16:0];
         rmsp_pkg::CSR_CENTERED: centered_q = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [30:0] lr, logic [30:0] eps, logic [16:0] dec,
                             logic [16:0] mom, logic cen);
      drain();
      write_csr(rmsp_pkg::CSR_STEP_SIZE, lr);
      write_csr(rmsp_pkg::CSR_EPSILON, eps);
      write_csr(rmsp_pkg::CSR_DECAY, {14'd0, dec});
      write_csr(rmsp_pkg::CSR_MOMENTUM, {14'd0, mom});
      write_csr(rmsp_pkg::CSR_CENTERED, {30'd0, cen});
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'd0;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom_range(0, 20'hFFFFF) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic element_type random_element();
      element_type e;
      logic [31:0] w;
      e.param = pick_word();
      w = pick_word();
      e.sq_avg = w[30:0];
      e.grad = pick_word();
      e.moment = pick_word();
      e.mean_grad = pick_word();
      return e;
   endfunction

   function automatic element_type make_element(logic [31:0] p, logic [30:0] ms,
                                                logic [31:0] g, logic [31:0] m,
                                                logic [31:0] mg);
      element_type e;
      e.param = p;
      e.sq_avg = ms;
      e.grad = g;
      e.moment = m;
      e.mean_grad = mg;
      return e;
   endfunction

   task automatic test_reset_config;
      send_element(make_element(32'h0001_0000, 31'h0001_0000, 32'h0000_8000, 0, 0));
      send_element(make_element(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_element(make_element(32'h8000_0000, 31'd0, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000));
      send_element(make_element(32'hFFFF_FFFF, 31'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
   endtask

   task automatic test_root_clamp;
      set_config(31'h7FFF_FFFF, 31'd0, 17'd65536, 17'd65536, 1'b0);
      send_element(make_element(32'h0001_0000, 31'd0, 32'd0, 32'h0002_0000, 5));
      send_element(make_element(32'h8000_0000, 31'd0, 32'd0, 32'h7FFF_FFFF, 0));
      set_config(31'h7FFF_FFFF, 31'd0, 17'd0, 17'd0, 1'b1);
      send_element(make_element(0, 31'd0, 32'h7FFF_FFFF, 32'd3, 32'h1234_5678));
      send_element(make_element(32'h7FFF_FFFF, 31'd0, 32'h8000_0000, 0, 0));
      send_element(make_element(0, 31'd5, 32'h0000_0100, 0, 0));
   endtask

   task automatic test_centered;
      set_config(31'd66, 31'd1, 17'd62259, 17'd58982, 1'b1);
      send_element(make_element(32'h0001_0000, 31'h0000_4000, 32'h0000_2000,
                                32'h0000_1000, 32'h0000_0800));
      send_element(make_element(32'hFFF0_0000, 31'h0100_0000, 32'hFFFF_8000,
                                32'hFFFF_F000, 32'h7FFF_FFFF));
      send_element(make_element(0, 31'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000));
   endtask

   task automatic test_factor_saturation;
      set_config(31'd0, 31'h7FFF_FFFF, 17'h1FFFF, 17'h1FFFF, 1'b0);
      send_element(make_element(32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h1));
      send_element(make_element(32'h7FFF_FFFF, 31'd0, 32'h8000_0000, 32'h8000_0000, 0));
      set_config(31'h7FFF_FFFF, 31'd1, 17'd65537, 17'd0, 1'b1);
      send_element(make_element(32'h7FFF_FFFF, 31'd0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF));
      send_element(make_element(32'h8000_0000, 31'd0, 32'h8000_0000, 0, 32'h0000_0001));
   endtask

   task automatic random_config;
      logic [30:0] lr;
      logic [30:0] eps;
      logic [16:0] dec;
      logic [16:0] mom;
      case ($urandom_range(3))
         0: lr = 31'h7FFF_FFFF;
         1: lr = 31'($urandom_range(0, 1000));
         default: lr = 31'($urandom);
      endcase
      case ($urandom_range(3))
         0: eps = 31'd0;
         1: eps = 31'h7FFF_FFFF;
         2: eps = 31'($urandom_range(0, 100));
         default: eps = 31'($urandom);
      endcase
      dec = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      mom = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      set_config(lr, eps, dec, mom, 1'($urandom));
   endtask

   task automatic test_random(int pct, int count);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         if (i % 130 == 0) random_config();
         send_element(random_element());
      end
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_param_value <= '0;
      req_sq_avg_value <= '0;
      req_gradient <= '0;
      req_moment_value <= '0;
      req_mean_grad_value <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      lr_q = 31'd66;
      eps_q = 31'd1;
      decay_q = 17'd62259;
      momentum_q = 17'd0;
      centered_q = 1'b0;
      mismatches = 0;
      cycles = 0;
      idle_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_root_clamp();
      test_centered();
      test_factor_saturation();
      test_random(0, 540);
      test_random(71, 530);
      test_random(29, 530);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && pending_updates.size() == 0) begin
         $display("rmsprop_param_update_core_test passed");
      end else begin
         $display("rmsprop_param_update_core_test failed");
      end
      $finish;
   end

endmodule
